/* sv/fys_pkg.sv */
// Shared types, constants and helpers for the random permutation shuffle core.
// Used by fys_mod_serial, fys_slot_ram and random_permutation_shuffle_core.
`timescale 1ns / 1ps
`default_nettype none

package fys_pkg;

  localparam int MAX_ENTRIES = 8192;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int WORD_W      = 31;
  localparam int DIV_CNT_W   = $clog2(WORD_W);
  localparam int CFG_W       = 14;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RDJ,
    ST_CAPJ,
    ST_DONE
  } fys_state_e;

  // One table row: round tag and stored index value.
  typedef struct packed {
    logic             tag;
    logic [IDX_W-1:0] value;
  } fys_row_t;

  // Write request into the slot table.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    fys_row_t         row;
  } fys_wr_t;

  // Status of the bit-serial modulo unit.
  typedef struct packed {
    logic busy;
    logic done;
  } fys_div_stat_t;

  // A count of zero is taken as one; anything above the table size saturates.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    begin
      if (v == '0) begin
        r = CNT_W'(1);
      end else if (32'(v) > 32'(MAX_ENTRIES)) begin
        r = CNT_W'(MAX_ENTRIES);
      end else begin
        r = CNT_W'(v);
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

/* sv/random_permutation_shuffle_core.sv */
// Fisher-Yates permutation generator. Each input transaction carries one 31-bit random
// word; the core reduces it modulo (i+1) for the current slot i, which counts down from
// n_entries-1 to 0, swaps slots i and j in an internal table and returns one output
// transaction with slot i and its final value, tlast marking slot 0 (end of a permutation).
// The next transaction then begins a fresh round over the current table. Each item is
// accepted in the idle state and reduced by the bit-serial modulo unit, which retires one
// word bit at a time and then flags completion; slot j is then read from the table in a
// registered read, captured as it is overwritten with the value of slot i, and its value
// written to slot i. The result is loaded into the output register in that last step; a
// stalled output side holds the core there until it can be loaded, and no new transaction
// is taken before then. After reset and after every write of n_entries the table is swept
// clean, one row per cycle over n_entries rows (8192 after reset), and no input is taken
// during that sweep. Depends on fys_pkg, fys_mod_serial and fys_slot_ram.
`timescale 1ns / 1ps
`default_nettype none

module random_permutation_shuffle_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: n_entries.
  input  wire logic        cfg_we_i,
  input  wire logic [13:0] cfg_wdata_i,
  // Input stream.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [30:0] random_word, [31] zero
  // Output stream.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [12:0] position, [25:13] entry, [31:26] zero
  output logic             m_axis_tlast_o    // last
);
  import fys_pkg::*;

  fys_state_e       state_q, state_d;
  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] n_m1;
  logic [IDX_W-1:0] cursor_q;
  logic             cur_tag_q;
  logic [IDX_W-1:0] clr_cnt_q;
  logic [IDX_W-1:0] rd_addr, rd_addr_q;
  logic [IDX_W-1:0] vi_q, vj_q;
  logic [IDX_W-1:0] rd_val;
  logic [IDX_W-1:0] j_idx;
  logic [CNT_W-1:0] divisor;
  fys_row_t         rd_row;
  fys_wr_t          wr;
  fys_div_stat_t    div_stat;
  logic             in_accept;
  logic             div_start;
  logic             out_load;
  logic             clear_last;

  logic             m_valid_q;
  logic [IDX_W-1:0] m_pos_q;
  logic [IDX_W-1:0] m_entry_q;
  logic             m_last_q;

  assign n_m1       = n_q - CNT_W'(1);
  assign clear_last = (clr_cnt_q == n_m1[IDX_W-1:0]);
  assign divisor    = {1'b0, cursor_q} + CNT_W'(1);
  assign in_accept  = s_axis_tvalid_i && s_axis_tready_o;

  // A row whose tag does not match the current round still holds its own index.
  assign rd_val = (rd_row.tag == cur_tag_q) ? rd_row.value : rd_addr_q;

  fys_mod_serial u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .word_i    (s_axis_tdata_i[WORD_W-1:0]),
    .divisor_i (divisor),
    .stat_o    (div_stat),
    .rem_o     (j_idx)
  );

  fys_slot_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_row)
  );

  // Next state. A configuration write always restarts the clearing sweep.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clear_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_accept) state_d = ST_DIV;
      ST_DIV:   if (div_stat.done) state_d = ST_RDJ;
      ST_RDJ:   state_d = ST_CAPJ;
      ST_CAPJ:  state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
    if (cfg_we_i) begin
      state_d = ST_CLEAR;
    end
  end

  // Datapath controls per state. Slot i is read throughout the division so its
  // value is waiting when the remainder is ready; slot j is read right after.
  always_comb begin
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    out_load        = 1'b0;
    rd_addr         = cursor_q;
    wr              = '0;
    unique case (state_q)
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_cnt_q;
      end
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        div_start       = s_axis_tvalid_i;
      end
      ST_DIV: begin
        rd_addr = cursor_q;
      end
      ST_RDJ: begin
        rd_addr = j_idx;
      end
      ST_CAPJ: begin
        rd_addr       = j_idx;
        wr.en         = 1'b1;
        wr.addr       = j_idx;
        wr.row.tag    = cur_tag_q;
        wr.row.value  = vi_q;
      end
      ST_DONE: begin
        // Slot i is written last so that it holds value j even when j equals i.
        wr.en        = 1'b1;
        wr.addr      = cursor_q;
        wr.row.tag   = cur_tag_q;
        wr.row.value = vj_q;
        out_load     = !m_valid_q || m_axis_tready_i;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      n_q       <= CNT_W'(MAX_ENTRIES);
      cursor_q  <= IDX_W'(MAX_ENTRIES - 1);
      cur_tag_q <= 1'b1;
      clr_cnt_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        n_q       <= clamp_count(cfg_wdata_i);
        cursor_q  <= IDX_W'(clamp_count(cfg_wdata_i) - CNT_W'(1));
        cur_tag_q <= 1'b1;
        clr_cnt_q <= '0;
      end else begin
        if (state_q == ST_CLEAR) begin
          clr_cnt_q <= clr_cnt_q + IDX_W'(1);
        end
        if (out_load) begin
          if (cursor_q == '0) begin
            cur_tag_q <= ~cur_tag_q;
            cursor_q  <= n_m1[IDX_W-1:0];
          end else begin
            cursor_q <= cursor_q - IDX_W'(1);
          end
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr;
    if (state_q == ST_RDJ) begin
      vi_q <= rd_val;
    end
    if (state_q == ST_CAPJ) begin
      vj_q <= rd_val;
    end
    if (out_load) begin
      m_pos_q   <= cursor_q;
      m_entry_q <= vj_q;
      m_last_q  <= (cursor_q == '0);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(32 - 2 * IDX_W)'(0), m_entry_q, m_pos_q};
  assign m_axis_tlast_o  = m_last_q;

`ifndef SYNTHESIS
  // The current slot never leaves the configured range.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cursor_q} < n_q))
    else $error("cursor outside configured range");

  // A result flagged last always carries slot zero.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tdata_o[IDX_W-1:0] == '0))
    else $error("last result with nonzero position");

  // The reduced word is always a valid slot at or below the current one.
  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> ({1'b0, j_idx} < divisor))
    else $error("remainder not below divisor");

  // No input is taken while the table sweep is running.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready_o)
    else $error("input accepted during table clear");
`endif

endmodule

`default_nettype wire

/* sv/fys_mod_serial.sv */
// Bit-serial restoring modulo: remainder of a random word by a narrow divisor.
// One dividend bit per cycle; depends on fys_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fys_mod_serial (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [fys_pkg::WORD_W-1:0] word_i,
  input  wire logic [fys_pkg::CNT_W-1:0]  divisor_i,
  output fys_pkg::fys_div_stat_t        stat_o,
  output logic [fys_pkg::IDX_W-1:0]     rem_o
);
  import fys_pkg::*;

  logic [WORD_W-1:0]    sh_q, sh_d;
  logic [IDX_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     trial;
  logic [CNT_W-1:0]     trial_red;

  // The partial remainder stays below the divisor, so it fits the index width.
  assign trial     = {rem_q, sh_q[WORD_W-1]};
  assign trial_red = (trial >= divisor_i) ? (trial - divisor_i) : trial;

  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d   = word_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d  = {sh_q[WORD_W-2:0], 1'b0};
      rem_d = trial_red[IDX_W-1:0];
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* sv/fys_slot_ram.sv */
// Slot table: one row per permutation slot holding a round tag and a value.
// One write and one registered read per cycle; depends on fys_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fys_slot_ram (
  input  wire logic                   clk_i,
  input  fys_pkg::fys_wr_t            wr_i,
  input  wire logic [fys_pkg::IDX_W-1:0] rd_addr_i,
  output fys_pkg::fys_row_t           rd_data_o
);
  import fys_pkg::*;

  fys_row_t mem [MAX_ENTRIES];
  fys_row_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.row;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire
